@@ rtl/ysc_pkg.sv @@
// Package: item types, character constants, parse phases and keyword tables.
package ysc_pkg;

    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_scalar;
    } t_in_item;

    typedef enum logic [2:0] {
        CLS_STRING = 3'd0,
        CLS_NULL   = 3'd1,
        CLS_BOOL   = 3'd2,
        CLS_INT    = 3'd3,
        CLS_FLOAT  = 3'd4
    } t_class;

    typedef struct packed {
        logic [2:0] scalar_class;
        logic       bool_value;
    } t_res_item;

    typedef struct packed {
        logic      valid;
        t_res_item data;
    } t_res_wr;

    typedef enum logic [1:0] {
        KW_NONE  = 2'd0,
        KW_NULL  = 2'd1,
        KW_TRUE  = 2'd2,
        KW_FALSE = 2'd3
    } t_kw;

    typedef enum logic [9:0] {
        PH_START    = 10'b00_0000_0001,
        PH_KEYWORD  = 10'b00_0000_0010,
        PH_MINUS    = 10'b00_0000_0100,
        PH_ZERO     = 10'b00_0000_1000,
        PH_INT      = 10'b00_0001_0000,
        PH_FRAC     = 10'b00_0010_0000,
        PH_EXP_MARK = 10'b00_0100_0000,
        PH_EXP_SIGN = 10'b00_1000_0000,
        PH_EXP_DIG  = 10'b01_0000_0000,
        PH_TEXT     = 10'b10_0000_0000
    } t_phase;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;

    function automatic logic [2:0] kw_len(input t_kw ch);
        logic [2:0] len;
        case (ch)
            KW_NULL:  len = 3'd4;
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input t_kw ch, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (ch)
            KW_NULL: begin
                case (pos)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            KW_TRUE: begin
                case (pos)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/ysc_parser.sv @@
// Front end: takes scalar bytes, runs the parse state machine, emits a class per scalar.
module ysc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ysc_pkg::t_in_item i_item,
    input  logic              i_full,
    output ysc_pkg::t_res_wr  o_wr
);

    ysc_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    ysc_pkg::t_kw    r_choice, n_choice;
    logic            w_acc;
    logic            w_done;
    logic            w_dig;
    logic            w_exp;
    logic [7:0]      w_c;
    ysc_pkg::t_class w_cls;
    logic            w_bool;

    assign w_c    = i_item.char_code;
    assign w_acc  = i_push && !i_full;
    assign w_done = i_item.last_char || i_item.empty_scalar;
    assign w_dig  = (w_c >= ysc_pkg::CH_0) && (w_c <= ysc_pkg::CH_9);
    assign w_exp  = (w_c == ysc_pkg::CH_E_LO) || (w_c == ysc_pkg::CH_E_UP);

    always_comb begin
        n_phase  = ysc_pkg::PH_TEXT;
        n_pos    = r_pos;
        n_choice = r_choice;
        unique case (r_phase) inside
            ysc_pkg::PH_START: begin
                if (w_c == ysc_pkg::CH_N) begin
                    n_choice = ysc_pkg::KW_NULL;
                    n_pos    = 3'd1;
                    n_phase  = ysc_pkg::PH_KEYWORD;
                end else if (w_c == ysc_pkg::CH_T) begin
                    n_choice = ysc_pkg::KW_TRUE;
                    n_pos    = 3'd1;
                    n_phase  = ysc_pkg::PH_KEYWORD;
                end else if (w_c == ysc_pkg::CH_F) begin
                    n_choice = ysc_pkg::KW_FALSE;
                    n_pos    = 3'd1;
                    n_phase  = ysc_pkg::PH_KEYWORD;
                end else if (w_c == ysc_pkg::CH_MINUS) begin
                    n_phase = ysc_pkg::PH_MINUS;
                end else if (w_c == ysc_pkg::CH_0) begin
                    n_phase = ysc_pkg::PH_ZERO;
                end else if (w_dig) begin
                    n_phase = ysc_pkg::PH_INT;
                end
            end
            ysc_pkg::PH_KEYWORD: begin
                if (r_choice != ysc_pkg::KW_NONE && r_pos < ysc_pkg::kw_len(r_choice)
                        && ysc_pkg::kw_char(r_choice, r_pos) == w_c) begin
                    n_pos   = r_pos + 3'd1;
                    n_phase = ysc_pkg::PH_KEYWORD;
                end
            end
            ysc_pkg::PH_MINUS: begin
                if (w_c == ysc_pkg::CH_0)
                    n_phase = ysc_pkg::PH_ZERO;
                else if (w_dig)
                    n_phase = ysc_pkg::PH_INT;
            end
            ysc_pkg::PH_ZERO: begin
                if (w_c == ysc_pkg::CH_DOT)
                    n_phase = ysc_pkg::PH_FRAC;
                else if (w_exp)
                    n_phase = ysc_pkg::PH_EXP_MARK;
            end
            ysc_pkg::PH_INT: begin
                if (w_dig)
                    n_phase = ysc_pkg::PH_INT;
                else if (w_c == ysc_pkg::CH_DOT)
                    n_phase = ysc_pkg::PH_FRAC;
                else if (w_exp)
                    n_phase = ysc_pkg::PH_EXP_MARK;
            end
            ysc_pkg::PH_FRAC: begin
                if (w_dig)
                    n_phase = ysc_pkg::PH_FRAC;
                else if (w_exp)
                    n_phase = ysc_pkg::PH_EXP_MARK;
            end
            ysc_pkg::PH_EXP_MARK: begin
                if (w_c == ysc_pkg::CH_PLUS || w_c == ysc_pkg::CH_MINUS)
                    n_phase = ysc_pkg::PH_EXP_SIGN;
                else if (w_dig)
                    n_phase = ysc_pkg::PH_EXP_DIG;
            end
            ysc_pkg::PH_EXP_SIGN, ysc_pkg::PH_EXP_DIG: begin
                if (w_dig)
                    n_phase = ysc_pkg::PH_EXP_DIG;
            end
            default: n_phase = ysc_pkg::PH_TEXT;
        endcase
    end

    // class of the scalar if this byte is its last
    always_comb begin
        w_cls  = ysc_pkg::CLS_STRING;
        w_bool = 1'b0;
        unique case (n_phase) inside
            ysc_pkg::PH_KEYWORD: begin
                if (n_choice != ysc_pkg::KW_NONE && n_pos == ysc_pkg::kw_len(n_choice)) begin
                    if (n_choice == ysc_pkg::KW_NULL) begin
                        w_cls = ysc_pkg::CLS_NULL;
                    end else begin
                        w_cls  = ysc_pkg::CLS_BOOL;
                        w_bool = (n_choice == ysc_pkg::KW_TRUE);
                    end
                end
            end
            ysc_pkg::PH_ZERO, ysc_pkg::PH_INT:     w_cls = ysc_pkg::CLS_INT;
            ysc_pkg::PH_FRAC, ysc_pkg::PH_EXP_DIG: w_cls = ysc_pkg::CLS_FLOAT;
            default:                               w_cls = ysc_pkg::CLS_STRING;
        endcase
    end

    always_comb begin
        o_wr.valid = w_acc && w_done;
        if (i_item.empty_scalar) begin
            o_wr.data.scalar_class = ysc_pkg::CLS_STRING;
            o_wr.data.bool_value   = 1'b0;
        end else begin
            o_wr.data.scalar_class = w_cls;
            o_wr.data.bool_value   = w_bool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ysc_pkg::PH_START;
            r_pos    <= 3'd0;
            r_choice <= ysc_pkg::KW_NONE;
        end else if (w_acc) begin
            if (w_done) begin
                r_phase  <= ysc_pkg::PH_START;
                r_pos    <= 3'd0;
                r_choice <= ysc_pkg::KW_NONE;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_choice <= n_choice;
            end
        end
    end

endmodule

@@ rtl/ysc_res_queue.sv @@
// Back end: short result queue between the parser and the result port.
module ysc_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ysc_pkg::t_res_wr   i_wr,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ysc_pkg::t_res_item o_res
);

    ysc_pkg::t_res_item                r_mem [ysc_pkg::RES_DEPTH];
    logic [ysc_pkg::RES_PTR_W-1:0]     r_wr_ptr;
    logic [ysc_pkg::RES_PTR_W-1:0]     r_rd_ptr;
    logic [ysc_pkg::RES_CNT_W-1:0]     r_count;
    logic                              w_rd;

    assign o_full  = (r_count == ysc_pkg::RES_CNT_W'(ysc_pkg::RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid)
            r_mem[r_wr_ptr] <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid)
                r_wr_ptr <= r_wr_ptr + ysc_pkg::RES_PTR_W'(1);
            if (w_rd)
                r_rd_ptr <= r_rd_ptr + ysc_pkg::RES_PTR_W'(1);
            case ({i_wr.valid, w_rd})
                2'b10:   r_count <= r_count + ysc_pkg::RES_CNT_W'(1);
                2'b01:   r_count <= r_count - ysc_pkg::RES_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/yaml_scalar_classifier.sv @@
// Top level: plain-scalar classifier with byte input queue port and result queue port.
//
// Input side: present one byte (or a lone empty-scalar item) on i_item with push high;
// the transfer happens on a rising edge with full low. Bytes of one scalar arrive in
// order, the final one marked by last_char.
// Result side: while empty is low the oldest class is on o_res; pulling pop high
// completes the transfer on that edge.
// Throughput: one byte per cycle while full is low, from the parse state machine.
// Latency: a result enters the result queue the cycle after its final byte is taken.
// Two results can wait in the result queue; full rises only while both slots are
// occupied, so a stalled receiver holds back input after two finished scalars.
// Reset (synchronous, active low) returns the parser to the start of a scalar and
// empties the result queue; any partial scalar is dropped.
module yaml_scalar_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ysc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ysc_pkg::t_res_item o_res
);

    ysc_pkg::t_res_wr w_wr;

    ysc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (full),
        .o_wr    (w_wr)
    );

    ysc_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_res   (o_res)
    );

`ifndef SYNTH
    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full && (i_item.last_char || i_item.empty_scalar) |=> !empty)
        else $error("finished scalar did not reach the result queue");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full and empty together");

    a_bool_only_for_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.bool_value |-> o_res.scalar_class == ysc_pkg::CLS_BOOL)
        else $error("bool value set on a non-bool class");

    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !(push && !full && (i_item.last_char || i_item.empty_scalar)) |=> empty)
        else $error("result appeared without a finished scalar");
`endif

endmodule

@@ verif/tb_yaml_scalar_classifier.sv @@
// Testbench for yaml_scalar_classifier: directed and random scalars checked against a class predictor.
`timescale 1ns / 100ps

module tb_yaml_scalar_classifier;
    import ysc_pkg::*;

    localparam int ITEM_TARGET    = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 5;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  i_item = '0;
    t_res_item o_res;

    yaml_scalar_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    string kw_word [4] = '{"", "null", "true", "false"};

    // predictor state
    t_phase     scan_phase = PH_START;
    logic [2:0] kw_matched = 3'd0;
    t_kw        kw_sel     = KW_NONE;

    t_res_item  pending_classes [$];
    logic [7:0] txt_q [$];
    int         mismatches = 0;
    int         items_sent = 0;
    bit         idle_on = 1'b1;
    int         quiet_cycles = 0;
    int         pop_wait = 0;

    function automatic bit is_num_char(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_exp_mark(logic [7:0] c);
        return c == CH_E_LO || c == CH_E_UP;
    endfunction

    function automatic logic [7:0] rand_digit(bit nonzero);
        return CH_0 + 8'($urandom_range(nonzero ? 1 : 0, 9));
    endfunction

    function automatic void add_txt(logic [7:0] b);
        txt_q.insert(txt_q.size(), b);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 200) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // advance the scan by one accepted byte and queue the class on a final byte or an empty scalar
    function automatic void classify_byte(t_in_item it);
        t_res_item  r;
        logic [7:0] c;
        t_phase     nx;
        c = it.char_code;
        r.scalar_class = CLS_STRING;
        r.bool_value   = 1'b0;
        if (it.empty_scalar) begin
            scan_phase = PH_START;
            kw_matched = 3'd0;
            kw_sel     = KW_NONE;
            pending_classes.insert(pending_classes.size(), r);
            return;
        end
        nx = PH_TEXT;
        case (scan_phase)
            PH_START: begin
                if (c == CH_N || c == CH_T || c == CH_F) begin
                    kw_sel     = (c == CH_N) ? KW_NULL : (c == CH_T) ? KW_TRUE : KW_FALSE;
                    kw_matched = 3'd1;
                    nx         = PH_KEYWORD;
                end else if (c == CH_MINUS) nx = PH_MINUS;
                else if (c == CH_0) nx = PH_ZERO;
                else if (is_num_char(c)) nx = PH_INT;
            end
            PH_KEYWORD: begin
                if (kw_sel != KW_NONE && kw_matched < kw_word[kw_sel].len()
                        && kw_word[kw_sel][kw_matched] == c) begin
                    kw_matched = kw_matched + 3'd1;
                    nx         = PH_KEYWORD;
                end
            end
            PH_MINUS: begin
                if (c == CH_0) nx = PH_ZERO;
                else if (is_num_char(c)) nx = PH_INT;
            end
            PH_ZERO: begin
                if (c == CH_DOT) nx = PH_FRAC;
                else if (is_exp_mark(c)) nx = PH_EXP_MARK;
            end
            PH_INT: begin
                if (is_num_char(c)) nx = PH_INT;
                else if (c == CH_DOT) nx = PH_FRAC;
                else if (is_exp_mark(c)) nx = PH_EXP_MARK;
            end
            PH_FRAC: begin
                if (is_num_char(c)) nx = PH_FRAC;
                else if (is_exp_mark(c)) nx = PH_EXP_MARK;
            end
            PH_EXP_MARK: begin
                if (c == CH_PLUS || c == CH_MINUS) nx = PH_EXP_SIGN;
                else if (is_num_char(c)) nx = PH_EXP_DIG;
            end
            PH_EXP_SIGN, PH_EXP_DIG: begin
                if (is_num_char(c)) nx = PH_EXP_DIG;
            end
            default: nx = PH_TEXT;
        endcase
        scan_phase = nx;
        if (!it.last_char) return;
        case (scan_phase)
            PH_KEYWORD: begin
                if (kw_sel != KW_NONE && kw_matched == kw_word[kw_sel].len()) begin
                    r.scalar_class = (kw_sel == KW_NULL) ? CLS_NULL : CLS_BOOL;
                    r.bool_value   = (kw_sel == KW_TRUE);
                end
            end
            PH_ZERO, PH_INT:     r.scalar_class = CLS_INT;
            PH_FRAC, PH_EXP_DIG: r.scalar_class = CLS_FLOAT;
            default:             r.scalar_class = CLS_STRING;
        endcase
        scan_phase = PH_START;
        kw_matched = 3'd0;
        kw_sel     = KW_NONE;
        pending_classes.insert(pending_classes.size(), r);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        classify_byte(it);
        items_sent++;
    endtask

    task automatic send_empty();
        t_in_item it;
        it.char_code    = 8'($urandom_range(0, 255));
        it.last_char    = 1'($urandom_range(0, 1));
        it.empty_scalar = 1'b1;
        send_item(it);
    endtask

    // sends txt_q as one scalar; a noisy send may cut in with an empty scalar
    task automatic send_text(input bit noisy);
        t_in_item it;
        foreach (txt_q[i]) begin
            if (noisy && i > 0 && $urandom_range(0, 39) == 0) send_empty();
            it.char_code    = txt_q[i];
            it.last_char    = (i == txt_q.size() - 1);
            it.empty_scalar = 1'b0;
            send_item(it);
        end
    endtask

    task automatic send_scalar(input string s);
        txt_q.delete();
        for (int i = 0; i < s.len(); i++) add_txt(s[i]);
        send_text(1'b0);
    endtask

    function automatic void make_scalar();
        int    kind;
        int    n;
        string w;
        string cs;
        kind = $urandom_range(0, 99);
        cs   = "0123456789.-+eEntf";
        txt_q.delete();
        if (kind < 40) begin
            if ($urandom_range(0, 3) == 0) add_txt(CH_MINUS);
            if ($urandom_range(0, 4) == 0) begin
                add_txt(CH_0);
                if ($urandom_range(0, 5) == 0) add_txt(rand_digit(1'b0));
            end else begin
                add_txt(rand_digit(1'b1));
                repeat ($urandom_range(0, 4)) add_txt(rand_digit(1'b0));
            end
            if ($urandom_range(0, 1) == 1) begin
                add_txt(CH_DOT);
                repeat ($urandom_range(0, 3)) add_txt(rand_digit(1'b0));
            end
            if ($urandom_range(0, 4) < 2) begin
                add_txt($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
                n = $urandom_range(0, 2);
                if (n == 1) add_txt(CH_PLUS);
                if (n == 2) add_txt(CH_MINUS);
                n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
                repeat (n) add_txt(rand_digit(1'b0));
            end
            if ($urandom_range(0, 9) == 0)
                txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind < 70) begin
            w = kw_word[$urandom_range(1, 3)];
            for (int i = 0; i < w.len(); i++) add_txt(w[i]);
            n = $urandom_range(0, 9);
            if (n == 6) txt_q = txt_q[0:$urandom_range(0, txt_q.size() - 2)];
            else if (n == 7) add_txt(8'($urandom_range(0, 255)));
            else if (n >= 8)
                txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) add_txt(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) add_txt(cs[$urandom_range(0, cs.len() - 1)]);
        end
    endfunction

    // result side: random stalls, checked against the oldest pending class
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_classes.size() == 0) begin
                report_mismatch($sformatf("class %0d transferred with nothing pending",
                                          o_res.scalar_class));
            end else begin
                if (o_res.scalar_class !== pending_classes[0].scalar_class)
                    report_mismatch($sformatf("scalar_class got %0d want %0d",
                        o_res.scalar_class, pending_classes[0].scalar_class));
                if (o_res.bool_value !== pending_classes[0].bool_value)
                    report_mismatch($sformatf("bool_value got %0d want %0d",
                        o_res.bool_value, pending_classes[0].bool_value));
                void'(pending_classes.pop_front());
            end
        end
        if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            pop      <= 1'b0;
            pop_wait = pick_gap();
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_keywords();
        send_scalar("null");
        send_scalar("true");
        send_scalar("false");
    endtask

    task automatic test_numbers();
        send_scalar("7");
        send_scalar("0.e+5");
    endtask

    task automatic test_special_cases();
        t_in_item it;
        // partial scalar dropped by an empty scalar, at the top byte value
        it = '{char_code: 8'hFF, last_char: 1'b0, empty_scalar: 1'b0};
        send_item(it);
        send_empty();
        send_scalar("-");
        send_scalar("05");
        send_scalar("1.");
        send_scalar(".5");
        send_scalar("1e");
        send_scalar("nulls");
    endtask

    task automatic test_byte_extremes();
        t_in_item it;
        it = '{char_code: 8'h00, last_char: 1'b1, empty_scalar: 1'b0};
        send_item(it);
    endtask

    task automatic test_random_scalars(input int upto, input bit idle);
        idle_on = idle;
        while (items_sent < upto) begin
            if ($urandom_range(0, 19) == 0) begin
                send_empty();
            end else begin
                make_scalar();
                send_text(1'b1);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_keywords();
        test_numbers();
        test_special_cases();
        test_byte_extremes();
        test_random_scalars(400, 1'b1);
        test_random_scalars(550, 1'b0);
        test_random_scalars(ITEM_TARGET, 1'b1);
        push <= 1'b0;
        while (pending_classes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
